[rtl/core/ntf_pkg.sv]
// Package with the shared types, constants and character tables of the number formatter.
`timescale 1ns / 1ps
package ntf_pkg;

  localparam int MaxWidthDefault = 20;

  localparam logic [2:0] STYLE_DEC    = 3'd0;
  localparam logic [2:0] STYLE_ROM_LO = 3'd1;
  localparam logic [2:0] STYLE_ROM_UP = 3'd2;
  localparam logic [2:0] STYLE_ALP_LO = 3'd3;
  localparam logic [2:0] STYLE_ALP_UP = 3'd4;

  localparam logic [31:0] RomanLimit = 32'd39999;
  // Reciprocals for the constant divisions: x / 10 = (x * RecipDec) >> 35,
  // x / 26 = (x * RecipAlp) >> 36, both exact for every 32-bit x in use.
  localparam logic [31:0] RecipDec = 32'hCCCC_CCCD;
  localparam logic [31:0] RecipAlp = 32'h9D89_D89E;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharQuery = 8'h3F;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CaseBit   = 8'h20;

  typedef enum logic [1:0] {
    CLS_DEC,
    CLS_ROM,
    CLS_ALP
  } cls_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         style;
    logic [4:0]         min_digits;
  } num_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
    logic       range_error;
  } txt_t;

  // One classified item as it waits between the front and the back.
  typedef struct packed {
    logic [31:0] mag;
    logic        neg;
    cls_t        cls;
    logic        upper;
    logic        zero;
    logic        err;
    logic [5:0]  width;
  } job_t;

  function automatic logic [7:0] roman_one(input logic [2:0] p, input logic upper);
    logic [7:0] ch;
    unique case (p)
      3'd0:    ch = 8'h69; // i
      3'd1:    ch = 8'h78; // x
      3'd2:    ch = 8'h63; // c
      3'd3:    ch = 8'h6D; // m
      default: ch = 8'h7A; // z
    endcase
    return upper ? (ch & ~CaseBit) : ch;
  endfunction

  function automatic logic [7:0] roman_five(input logic [2:0] p, input logic upper);
    logic [7:0] ch;
    unique case (p)
      3'd0:    ch = 8'h76; // v
      3'd1:    ch = 8'h6C; // l
      3'd2:    ch = 8'h64; // d
      default: ch = 8'h77; // w
    endcase
    return upper ? (ch & ~CaseBit) : ch;
  endfunction

endpackage

[rtl/core/ntf_front.sv]
// Front end: classifies an incoming number into magnitude, sign, style class and width.
`timescale 1ns / 1ps
module ntf_front import ntf_pkg::*; #(
  parameter int MAX_WIDTH = MaxWidthDefault
) (
  input  num_t num,
  output job_t job
);

  logic [31:0] raw;
  logic        neg;
  logic [31:0] mag;
  cls_t        cls;

  assign raw = num.value;
  assign neg = raw[31];
  assign mag = neg ? (32'd0 - raw) : raw;

  always_comb begin
    unique case (num.style)
      STYLE_ROM_LO, STYLE_ROM_UP: cls = CLS_ROM;
      STYLE_ALP_LO, STYLE_ALP_UP: cls = CLS_ALP;
      default:                    cls = CLS_DEC;
    endcase
  end

  always_comb begin
    job.mag   = mag;
    job.neg   = neg;
    job.cls   = cls;
    job.upper = (num.style == STYLE_ROM_UP) || (num.style == STYLE_ALP_UP);
    job.zero  = (mag == 32'd0);
    job.err   = (cls == CLS_ROM) && (mag > RomanLimit);
    if (6'(num.min_digits) > 6'(MAX_WIDTH)) begin
      job.width = 6'(MAX_WIDTH);
    end else begin
      job.width = 6'(num.min_digits);
    end
  end

endmodule

[rtl/core/ntf_fifo.sv]
// Two-entry queue of classified items between the front and the back.
`timescale 1ns / 1ps
module ntf_fifo import ntf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_stall,
  input  job_t push_data,
  output logic pop_valid,
  input  logic pop,
  output job_t pop_data
);

  job_t       mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       push;

  assign push_stall = (count == 2'd2);
  assign push       = push_valid && !push_stall;
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        mem[wp] <= push_data;
        wp      <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

[rtl/core/ntf_back.sv]
// Back end: converts one item into digits and sends its characters out one word at a time.
`timescale 1ns / 1ps
module ntf_back import ntf_pkg::*; #(
  parameter int MAX_WIDTH = MaxWidthDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  input  job_t job,
  output logic pop,
  output logic txt_valid,
  input  logic txt_stall,
  output txt_t txt
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int IW = $clog2(MAX_WIDTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_PAD,
    S_SIGN,
    S_ZERO,
    S_BODY,
    S_ROMAN
  } state_t;

  state_t        state;
  job_t          cur;
  logic [31:0]   x;
  logic [63:0]   prod;
  logic [4:0]    dig [MAX_WIDTH];
  logic [CW-1:0] cnt;
  logic [CW-1:0] idx;
  logic [2:0]    p;
  logic [1:0]    j;
  logic          err_pend;
  logic          out_valid;
  txt_t          out;

  logic          slot;
  logic          emit;
  logic          is_alp;
  logic [31:0]   q;
  logic [31:0]   r;
  logic [CW-1:0] target;
  logic [7:0]    body_char;
  logic [3:0]    d;
  logic          d5;
  logic [3:0]    rem;
  logic [2:0]    len;
  logic          lower_nz;
  logic [7:0]    rom_char;
  logic          rom_end;
  state_t        body_state;

  assign slot      = !out_valid || !txt_stall;
  assign is_alp    = (cur.cls == CLS_ALP);
  assign pop       = (state == S_IDLE) && job_valid;
  assign txt_valid = out_valid;
  assign txt       = out;

  // High when a new word is loaded into the output register this cycle.
  assign emit = slot && (((state == S_SIGN) && (err_pend || cur.neg)) ||
                         (state == S_ZERO) || (state == S_BODY) ||
                         ((state == S_ROMAN) && (len != 3'd0)));

  assign q = is_alp ? 32'(prod[63:36]) : 32'(prod[63:35]);
  assign r = x - 32'(q * (is_alp ? 32'd26 : 32'd10));

  always_comb begin
    unique case (cur.cls)
      CLS_DEC: target = CW'(cur.width);
      CLS_ROM: target = CW'(5);
      default: target = '0;
    endcase
  end

  always_comb begin
    if (!is_alp) begin
      body_char = CharZero + 8'(dig[idx[IW-1:0]]);
    end else if (cur.upper) begin
      body_char = CharUpA + 8'(dig[idx[IW-1:0]]);
    end else begin
      body_char = CharLowA + 8'(dig[idx[IW-1:0]]);
    end
  end

  // Roman digit p expands to a short pattern; j walks through it.
  assign d   = dig[IW'(p)][3:0];
  assign d5  = (d >= 4'd5);
  assign rem = d5 ? (d - 4'd5) : d;
  assign len = (rem == 4'd4) ? 3'd2 : (3'(d5) + rem[2:0]);
  assign rom_end = (3'(j) == len - 3'd1);

  always_comb begin
    lower_nz = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if ((3'(k) < p) && (dig[k] != 5'd0)) begin
        lower_nz = 1'b1;
      end
    end
  end

  always_comb begin
    if (rem == 4'd4) begin
      if (j == 2'd0) begin
        rom_char = roman_one(p, cur.upper);
      end else if (d5) begin
        rom_char = roman_one(p + 3'd1, cur.upper);
      end else begin
        rom_char = roman_five(p, cur.upper);
      end
    end else if (d5 && (j == 2'd0)) begin
      rom_char = roman_five(p, cur.upper);
    end else begin
      rom_char = roman_one(p, cur.upper);
    end
  end

  always_comb begin
    if (cur.zero && (cur.cls != CLS_DEC)) begin
      body_state = S_ZERO;
    end else if (cur.cls == CLS_ROM) begin
      body_state = S_ROMAN;
    end else begin
      body_state = S_BODY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      err_pend  <= 1'b0;
    end else begin
      if (out_valid && !txt_stall && !emit) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            cur      <= job;
            x        <= (job.cls == CLS_ALP) ? (job.mag - 32'd1) : job.mag;
            cnt      <= '0;
            err_pend <= job.err;
            if (job.err || (job.zero && (job.cls != CLS_DEC))) begin
              state <= S_SIGN;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod  <= x * (is_alp ? RecipAlp : RecipDec);
          state <= S_DIV;
        end
        S_DIV: begin
          dig[cnt[IW-1:0]] <= r[4:0];
          cnt              <= cnt + 1'b1;
          x                <= is_alp ? (q - 32'd1) : q;
          state            <= (q == 32'd0) ? S_PAD : S_MUL;
        end
        S_PAD: begin
          if (cnt < target) begin
            dig[cnt[IW-1:0]] <= 5'd0;
            cnt              <= cnt + 1'b1;
          end else begin
            idx   <= cnt - 1'b1;
            p     <= 3'd4;
            j     <= 2'd0;
            state <= S_SIGN;
          end
        end
        S_SIGN: begin
          // An out-of-range roman value becomes a single flagged '?'.
          if (err_pend) begin
            if (slot) begin
              out_valid       <= 1'b1;
              out.char_code   <= CharQuery;
              out.last_char   <= 1'b1;
              out.range_error <= 1'b1;
              state           <= S_IDLE;
            end
          end else if (!cur.neg) begin
            state <= body_state;
          end else if (slot) begin
            out_valid       <= 1'b1;
            out.char_code   <= CharMinus;
            out.last_char   <= 1'b0;
            out.range_error <= 1'b0;
            state           <= body_state;
          end
        end
        S_ZERO: begin
          if (slot) begin
            out_valid       <= 1'b1;
            out.char_code   <= CharZero;
            out.last_char   <= 1'b1;
            out.range_error <= 1'b0;
            state           <= S_IDLE;
          end
        end
        S_BODY: begin
          if (slot) begin
            out_valid       <= 1'b1;
            out.char_code   <= body_char;
            out.last_char   <= (idx == '0);
            out.range_error <= 1'b0;
            idx             <= idx - 1'b1;
            if (idx == '0) begin
              state <= S_IDLE;
            end
          end
        end
        S_ROMAN: begin
          if (len == 3'd0) begin
            p <= p - 3'd1;
          end else if (slot) begin
            out_valid       <= 1'b1;
            out.char_code   <= rom_char;
            out.last_char   <= rom_end && !lower_nz;
            out.range_error <= 1'b0;
            if (rom_end) begin
              j <= 2'd0;
              p <= p - 3'd1;
              if (!lower_nz) begin
                state <= S_IDLE;
              end
            end else begin
              j <= j + 2'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/number_to_text_formatter_top.sv]
// Top level of the number formatter: front end, item queue and character back end.
//
//   channel | dir | payload | handshake
//   num     | in  | num_t   | num_valid / num_stall
//   txt     | out | txt_t   | txt_valid / txt_stall
//
// A decimal or roman item splits off each digit in the shared reciprocal
// multiplier (a 32 by 32 product, then quotient and remainder), adds its pad
// digits, then sends its characters out one word at a time. Alpha uses the
// same loop.
// Up to two items wait in the queue while the back end works.
// Reset is synchronous and clears the queue and the output word.
// A stalled output word holds; the back end waits on it.
`timescale 1ns / 1ps
module number_to_text_formatter_top import ntf_pkg::*; #(
  parameter int MAX_WIDTH = MaxWidthDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic num_valid,
  output logic num_stall,
  input  num_t num,
  output logic txt_valid,
  input  logic txt_stall,
  output txt_t txt
);

  job_t front_job;
  job_t queue_job;
  logic queue_valid;
  logic queue_pop;

  ntf_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .num (num),
    .job (front_job)
  );

  ntf_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (num_valid),
    .push_stall (num_stall),
    .push_data  (front_job),
    .pop_valid  (queue_valid),
    .pop        (queue_pop),
    .pop_data   (queue_job)
  );

  ntf_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (queue_valid),
    .job       (queue_job),
    .pop       (queue_pop),
    .txt_valid (txt_valid),
    .txt_stall (txt_stall),
    .txt       (txt)
  );

endmodule

[rtl/core/ntf_checker.sv]
// Port-level checks of the number formatter, bound to the top level.
`timescale 1ns / 1ps
module ntf_checker import ntf_pkg::*; (
  input logic clk,
  input logic rst,
  input logic txt_valid,
  input logic txt_stall,
  input txt_t txt
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    txt_valid && txt_stall |=> txt_valid && $stable(txt))
    else $error("stalled output word changed");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    txt_valid && txt.range_error |-> txt.last_char)
    else $error("range error word is not the last word");

  a_err_char: assert property (@(posedge clk) disable iff (rst)
    txt_valid && txt.range_error |-> txt.char_code == CharQuery)
    else $error("range error word is not a question mark");

  a_reset: assert property (@(posedge clk)
    rst |=> !txt_valid)
    else $error("output word valid right after reset");

endmodule

bind number_to_text_formatter_top ntf_checker u_ntf_checker (
  .clk       (clk),
  .rst       (rst),
  .txt_valid (txt_valid),
  .txt_stall (txt_stall),
  .txt       (txt)
);
